@@ src/sha_pkg.sv @@
package sha_pkg;

   localparam int RAW_DEPTH    = 256;
   localparam int COARSE_DEPTH = 128;
   localparam int RAW_AW       = (RAW_DEPTH > 1) ? $clog2(RAW_DEPTH) : 1;
   localparam int COARSE_AW    = (COARSE_DEPTH > 1) ? $clog2(COARSE_DEPTH) : 1;
   localparam int RAW_CW       = $clog2(RAW_DEPTH + 1);
   localparam int COARSE_CW    = $clog2(COARSE_DEPTH + 1);

   // raw entry: run, time, seq, temp, valid, fault
   localparam int RAW_EW    = 32 + 32 + 32 + 16 + 1 + 8;
   // coarse entry: run, start, avg, min, max, valid, fault
   localparam int COARSE_EW = 32 + 32 + 16 + 16 + 16 + 1 + 8;

   localparam int DIV_NW  = 48;
   localparam int DIV_DW  = 32;
   localparam int DIV_CNW = $clog2(DIV_NW);

   localparam logic [2:0] CMD_PUSH     = 3'd0;
   localparam logic [2:0] CMD_FLUSH    = 3'd1;
   localparam logic [2:0] CMD_CLEAR    = 3'd2;
   localparam logic [2:0] CMD_RESTORE  = 3'd3;
   localparam logic [2:0] CMD_RD_RAW   = 3'd4;
   localparam logic [2:0] CMD_RD_CRS   = 3'd5;
   localparam logic [2:0] CMD_CURRENT  = 3'd6;
   localparam logic [2:0] CMD_LATEST   = 3'd7;

   localparam logic [7:0]  NAN_FAULT_BIT      = 8'h01;
   localparam logic [31:0] BUCKET_WIDTH_RESET = 32'd1000;

   typedef struct packed {
      logic latch;
      logic upd_latest;
      logic new_run;
      logic clear;
      logic raw_wr;
      logic q_start;
      logic set_bq_t;
      logic set_bq_div;
      logic avg_start;
      logic open_bucket;
      logic close_wr;
      logic restore_wr;
      logic agg;
      logic rd_raw;
      logic rd_coarse;
      logic load_rsp;
   } sha_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       run_zero;
      logic       run_diff;
      logic       width_zero;
      logic       div_done;
      logic       bucket_open;
      logic       bq_older;
      logic       bq_same;
      logic       count_zero;
      logic       raw_idx_ok;
      logic       coarse_idx_ok;
   } sha_stat_type;

endpackage

@@ src/sha_ram.sv @@
module sha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sha_div.sv @@
module sha_div import sha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient,
   output logic [DIV_DW-1:0] remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_CNW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0]  quo_ff, quo_in;
   logic [DIV_DW-1:0]  rem_ff, rem_in;
   logic [DIV_DW-1:0]  dvs_ff, dvs_in;
   logic [DIV_DW:0]    rem_sh;
   logic               ge;

   // one quotient bit a cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_NW-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DW'(rem_sh - {1'b0, dvs_ff}) : DIV_DW'(rem_sh);
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNW'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/sha_dp.sv @@
module sha_dp import sha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  sha_cmd_type        cmd,
   output sha_stat_type       stat,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  logic [2:0]         req_cmd,
   input  logic [31:0]        req_run_id,
   input  logic [31:0]        req_time_ms,
   input  logic signed [15:0] req_temp,
   input  logic               req_temp_valid,
   input  logic [7:0]         req_fault_bits,
   input  logic [31:0]        req_seq,
   input  logic [7:0]         req_read_index,
   input  logic signed [15:0] req_min_temp,
   input  logic signed [15:0] req_max_temp,
   output logic               rsp_ok,
   output logic [31:0]        rsp_out_run,
   output logic [31:0]        rsp_out_ms,
   output logic signed [15:0] rsp_out_temp,
   output logic               rsp_out_temp_valid,
   output logic signed [15:0] rsp_out_min,
   output logic signed [15:0] rsp_out_max,
   output logic [7:0]         rsp_out_fault,
   output logic [31:0]        rsp_out_seq,
   output logic [RAW_CW-1:0]  rsp_raw_count,
   output logic [COARSE_CW-1:0] rsp_coarse_count,
   output logic [31:0]        rsp_current_run
);

   // latched request
   logic [2:0]         op_ff;
   logic [31:0]        r_run_ff, r_time_ff, r_seq_ff;
   logic signed [15:0] r_temp_ff, r_min_ff, r_max_ff;
   logic               r_valid_ff;
   logic [7:0]         r_fault_ff, r_idx_ff;

   logic [31:0] width_ff;

   logic [RAW_AW-1:0]    raw_head_ff, raw_head_in;
   logic [RAW_CW-1:0]    raw_size_ff, raw_size_in;
   logic [COARSE_AW-1:0] crs_head_ff, crs_head_in;
   logic [COARSE_CW-1:0] crs_size_ff, crs_size_in;
   logic [31:0]          run_reg_ff, run_reg_in;
   logic [31:0]          bstart_ff, bstart_in;
   logic signed [47:0]   bsum_ff, bsum_in;
   logic [31:0]          bcount_ff, bcount_in;
   logic signed [15:0]   bmin_ff, bmin_in, bmax_ff, bmax_in;
   logic [7:0]           bfault_ff, bfault_in;
   logic                 bopen_ff, bopen_in;
   logic [31:0]          bq_ff, bq_in;
   logic                 neg_ff, neg_in;

   logic [31:0]        lat_run_ff, lat_time_ff, lat_seq_ff;
   logic signed [15:0] lat_temp_ff;
   logic               lat_valid_ff, lat_has_ff;
   logic [7:0]         lat_fault_ff;

   logic               div_done;
   logic [DIV_NW-1:0]  div_quo, div_dividend;
   logic [DIV_DW-1:0]  div_rem, div_divisor;
   logic [47:0]        abs_sum;
   logic signed [15:0] avg_val;

   logic [RAW_EW-1:0]    raw_wdata, raw_rdata;
   logic [COARSE_EW-1:0] crs_wdata, crs_rdata;
   logic [RAW_AW-1:0]    raw_raddr;
   logic [COARSE_AW-1:0] crs_raddr;
   logic [31:0]          raw_p, crs_p;
   logic                 crs_wr;

   // result assembly
   logic               res_ok, res_valid;
   logic [31:0]        res_run, res_ms, res_seq;
   logic signed [15:0] res_temp, res_min, res_max;
   logic [7:0]         res_fault;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_cmd;
         r_run_ff   <= req_run_id;
         r_time_ff  <= req_time_ms;
         r_temp_ff  <= req_temp;
         r_valid_ff <= req_temp_valid;
         r_fault_ff <= req_fault_bits;
         r_seq_ff   <= req_seq;
         r_idx_ff   <= req_read_index;
         r_min_ff   <= req_min_temp;
         r_max_ff   <= req_max_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= BUCKET_WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // serial divider shared by bucket quantize and average
   assign abs_sum      = bsum_ff[47] ? 48'(-bsum_ff) : 48'(bsum_ff);
   assign div_dividend = cmd.avg_start ? abs_sum : DIV_NW'(r_time_ff);
   assign div_divisor  = cmd.avg_start ? bcount_ff : width_ff;

   sha_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.q_start | cmd.avg_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign avg_val = neg_ff ? 16'(-div_quo[15:0]) : div_quo[15:0];

   always_comb begin
      raw_head_in = raw_head_ff;
      raw_size_in = raw_size_ff;
      crs_head_in = crs_head_ff;
      crs_size_in = crs_size_ff;
      run_reg_in  = run_reg_ff;
      bstart_in   = bstart_ff;
      bsum_in     = bsum_ff;
      bcount_in   = bcount_ff;
      bmin_in     = bmin_ff;
      bmax_in     = bmax_ff;
      bfault_in   = bfault_ff;
      bopen_in    = bopen_ff;
      bq_in       = bq_ff;
      neg_in      = neg_ff;
      if (cmd.new_run || cmd.clear) begin
         raw_head_in = '0;
         raw_size_in = '0;
         crs_head_in = '0;
         crs_size_in = '0;
         bopen_in    = 1'b0;
         bsum_in     = '0;
         bcount_in   = '0;
         bfault_in   = '0;
         run_reg_in  = r_run_ff;
      end
      if (cmd.raw_wr) begin
         raw_head_in = (raw_head_ff == RAW_AW'(RAW_DEPTH - 1)) ? '0 : raw_head_ff + 1'b1;
         if (raw_size_ff != RAW_CW'(RAW_DEPTH)) begin
            raw_size_in = raw_size_ff + 1'b1;
         end
      end
      if (cmd.set_bq_t) begin
         bq_in = r_time_ff;
      end
      if (cmd.set_bq_div) begin
         bq_in = r_time_ff - div_rem;
      end
      if (cmd.avg_start) begin
         neg_in = bsum_ff[47];
      end
      if (cmd.open_bucket) begin
         bstart_in = bq_ff;
         bopen_in  = 1'b1;
      end
      if (cmd.close_wr || cmd.restore_wr) begin
         crs_head_in = (crs_head_ff == COARSE_AW'(COARSE_DEPTH - 1)) ? '0
                       : crs_head_ff + 1'b1;
         if (crs_size_ff != COARSE_CW'(COARSE_DEPTH)) begin
            crs_size_in = crs_size_ff + 1'b1;
         end
      end
      if (cmd.close_wr) begin
         bopen_in  = 1'b0;
         bsum_in   = '0;
         bcount_in = '0;
         bfault_in = '0;
      end
      if (cmd.restore_wr) begin
         run_reg_in = r_run_ff;
      end
      if (cmd.agg) begin
         bfault_in = bfault_ff | r_fault_ff | (r_valid_ff ? 8'h00 : NAN_FAULT_BIT);
         if (r_valid_ff) begin
            if (bcount_ff == '0) begin
               bmin_in = r_temp_ff;
               bmax_in = r_temp_ff;
            end else begin
               if (r_temp_ff < bmin_ff) bmin_in = r_temp_ff;
               if (r_temp_ff > bmax_ff) bmax_in = r_temp_ff;
            end
            // count saturates; sum follows it
            if (bcount_ff != '1) begin
               bsum_in   = bsum_ff + 48'(r_temp_ff);
               bcount_in = bcount_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_head_ff <= '0;
         raw_size_ff <= '0;
         crs_head_ff <= '0;
         crs_size_ff <= '0;
         run_reg_ff  <= '0;
         bstart_ff   <= '0;
         bsum_ff     <= '0;
         bcount_ff   <= '0;
         bmin_ff     <= '0;
         bmax_ff     <= '0;
         bfault_ff   <= '0;
         bopen_ff    <= 1'b0;
         lat_has_ff  <= 1'b0;
      end else begin
         raw_head_ff <= raw_head_in;
         raw_size_ff <= raw_size_in;
         crs_head_ff <= crs_head_in;
         crs_size_ff <= crs_size_in;
         run_reg_ff  <= run_reg_in;
         bstart_ff   <= bstart_in;
         bsum_ff     <= bsum_in;
         bcount_ff   <= bcount_in;
         bmin_ff     <= bmin_in;
         bmax_ff     <= bmax_in;
         bfault_ff   <= bfault_in;
         bopen_ff    <= bopen_in;
         if (cmd.upd_latest) begin
            lat_has_ff <= 1'b1;
         end
      end
      bq_ff  <= bq_in;
      neg_ff <= neg_in;
      if (cmd.upd_latest) begin
         lat_run_ff   <= r_run_ff;
         lat_time_ff  <= r_time_ff;
         lat_seq_ff   <= r_seq_ff;
         lat_temp_ff  <= r_valid_ff ? r_temp_ff : 16'sd0;
         lat_valid_ff <= r_valid_ff;
         lat_fault_ff <= r_fault_ff;
      end
   end

   // entries counted from the oldest; idx < size keeps the sum below twice the depth
   always_comb begin
      raw_p = 32'(raw_head_ff) + 32'(RAW_DEPTH) - 32'(raw_size_ff) + 32'(r_idx_ff);
      if (raw_p >= 32'(RAW_DEPTH)) raw_p = raw_p - 32'(RAW_DEPTH);
      crs_p = 32'(crs_head_ff) + 32'(COARSE_DEPTH) - 32'(crs_size_ff) + 32'(r_idx_ff);
      if (crs_p >= 32'(COARSE_DEPTH)) crs_p = crs_p - 32'(COARSE_DEPTH);
   end
   assign raw_raddr = RAW_AW'(raw_p);
   assign crs_raddr = COARSE_AW'(crs_p);

   assign raw_wdata = {r_run_ff, r_time_ff, r_seq_ff,
                       (r_valid_ff ? r_temp_ff : 16'sd0), r_valid_ff, r_fault_ff};

   always_comb begin
      if (cmd.restore_wr) begin
         crs_wdata = {r_run_ff, r_time_ff,
                      (r_valid_ff ? r_temp_ff : 16'sd0),
                      (r_valid_ff ? r_min_ff : 16'sd0),
                      (r_valid_ff ? r_max_ff : 16'sd0),
                      r_valid_ff, r_fault_ff};
      end else if (bcount_ff == '0) begin
         crs_wdata = {run_reg_ff, bstart_ff, 16'sd0, 16'sd0, 16'sd0, 1'b0, bfault_ff};
      end else begin
         crs_wdata = {run_reg_ff, bstart_ff, avg_val, bmin_ff, bmax_ff, 1'b1, bfault_ff};
      end
   end
   assign crs_wr = cmd.close_wr | cmd.restore_wr;

   sha_ram #(.WIDTH(RAW_EW), .DEPTH(RAW_DEPTH)) u_raw_ram (
      .clock   (clock),
      .wr_en   (cmd.raw_wr),
      .wr_addr (raw_head_ff),
      .wr_data (raw_wdata),
      .rd_en   (cmd.rd_raw),
      .rd_addr (raw_raddr),
      .rd_data (raw_rdata)
   );

   sha_ram #(.WIDTH(COARSE_EW), .DEPTH(COARSE_DEPTH)) u_crs_ram (
      .clock   (clock),
      .wr_en   (crs_wr),
      .wr_addr (crs_head_ff),
      .wr_data (crs_wdata),
      .rd_en   (cmd.rd_coarse),
      .rd_addr (crs_raddr),
      .rd_data (crs_rdata)
   );

   assign stat.op            = op_ff;
   assign stat.run_zero      = r_run_ff == '0;
   assign stat.run_diff      = r_run_ff != run_reg_ff;
   assign stat.width_zero    = width_ff == '0;
   assign stat.div_done      = div_done;
   assign stat.bucket_open   = bopen_ff;
   assign stat.bq_older      = bq_ff < bstart_ff;
   assign stat.bq_same       = bq_ff == bstart_ff;
   assign stat.count_zero    = bcount_ff == '0;
   assign stat.raw_idx_ok    = 32'(r_idx_ff) < 32'(raw_size_ff);
   assign stat.coarse_idx_ok = 32'(r_idx_ff) < 32'(crs_size_ff);

   always_comb begin
      res_ok    = 1'b0;
      res_valid = 1'b0;
      res_run   = '0;
      res_ms    = '0;
      res_seq   = '0;
      res_temp  = '0;
      res_min   = '0;
      res_max   = '0;
      res_fault = '0;
      case (op_ff)
         CMD_RD_RAW: begin
            if (stat.raw_idx_ok) begin
               res_ok = 1'b1;
               {res_run, res_ms, res_seq, res_temp, res_valid, res_fault} = raw_rdata;
            end
         end
         CMD_RD_CRS: begin
            if (stat.coarse_idx_ok) begin
               res_ok = 1'b1;
               {res_run, res_ms, res_temp, res_min, res_max, res_valid, res_fault} =
                  crs_rdata;
            end
         end
         CMD_CURRENT: begin
            if (bopen_ff) begin
               res_ok    = 1'b1;
               res_run   = run_reg_ff;
               res_ms    = bstart_ff;
               res_fault = bfault_ff;
               if (bcount_ff != '0) begin
                  res_valid = 1'b1;
                  res_temp  = avg_val;
                  res_min   = bmin_ff;
                  res_max   = bmax_ff;
               end
            end
         end
         CMD_LATEST: begin
            if (lat_has_ff) begin
               res_ok    = 1'b1;
               res_run   = lat_run_ff;
               res_ms    = lat_time_ff;
               res_temp  = lat_temp_ff;
               res_valid = lat_valid_ff;
               res_fault = lat_fault_ff;
               res_seq   = lat_seq_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok             <= res_ok;
         rsp_out_run        <= res_run;
         rsp_out_ms         <= res_ms;
         rsp_out_temp       <= res_temp;
         rsp_out_temp_valid <= res_valid;
         rsp_out_min        <= res_min;
         rsp_out_max        <= res_max;
         rsp_out_fault      <= res_fault;
         rsp_out_seq        <= res_seq;
         rsp_raw_count      <= raw_size_ff;
         rsp_coarse_count   <= crs_size_ff;
         rsp_current_run    <= run_reg_ff;
      end
   end

endmodule

@@ src/sha_ctrl.sv @@
module sha_ctrl import sha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  sha_stat_type stat,
   output sha_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DECODE  = 4'd1;
   localparam logic [3:0] ST_PUSH1   = 4'd2;
   localparam logic [3:0] ST_PUSH2   = 4'd3;
   localparam logic [3:0] ST_QWAIT   = 4'd4;
   localparam logic [3:0] ST_PBUCK   = 4'd5;
   localparam logic [3:0] ST_AVGWAIT = 4'd6;
   localparam logic [3:0] ST_CLOSE   = 4'd7;
   localparam logic [3:0] ST_REOPEN  = 4'd8;
   localparam logic [3:0] ST_AGG     = 4'd9;
   localparam logic [3:0] ST_RDWAIT  = 4'd10;
   localparam logic [3:0] ST_FIN     = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       take;

   assign take      = rsp_valid_ff & ~rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FIN;
            case (stat.op)
               CMD_PUSH: begin
                  cmd.upd_latest = 1'b1;
                  if (!stat.run_zero) state_in = ST_PUSH1;
               end
               CMD_FLUSH: begin
                  if (stat.bucket_open) begin
                     if (stat.count_zero) begin
                        state_in = ST_CLOSE;
                     end else begin
                        cmd.avg_start = 1'b1;
                        state_in      = ST_AVGWAIT;
                     end
                  end
               end
               CMD_CLEAR: cmd.clear = 1'b1;
               CMD_RESTORE: cmd.restore_wr = !stat.run_zero;
               CMD_RD_RAW: begin
                  if (stat.raw_idx_ok) begin
                     cmd.rd_raw = 1'b1;
                     state_in   = ST_RDWAIT;
                  end
               end
               CMD_RD_CRS: begin
                  if (stat.coarse_idx_ok) begin
                     cmd.rd_coarse = 1'b1;
                     state_in      = ST_RDWAIT;
                  end
               end
               CMD_CURRENT: begin
                  if (stat.bucket_open && !stat.count_zero) begin
                     cmd.avg_start = 1'b1;
                     state_in      = ST_AVGWAIT;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_PUSH1: begin
            cmd.new_run = stat.run_diff;
            state_in    = ST_PUSH2;
         end
         ST_PUSH2: begin
            cmd.raw_wr = 1'b1;
            if (stat.width_zero) begin
               cmd.set_bq_t = 1'b1;
               state_in     = ST_PBUCK;
            end else begin
               cmd.q_start = 1'b1;
               state_in    = ST_QWAIT;
            end
         end
         ST_QWAIT: begin
            if (stat.div_done) begin
               cmd.set_bq_div = 1'b1;
               state_in       = ST_PBUCK;
            end
         end
         ST_PBUCK: begin
            if (!stat.bucket_open) begin
               cmd.open_bucket = 1'b1;
               state_in        = ST_AGG;
            end else if (stat.bq_older) begin
               // late sample: raw only
               state_in = ST_FIN;
            end else if (stat.bq_same) begin
               state_in = ST_AGG;
            end else if (stat.count_zero) begin
               state_in = ST_CLOSE;
            end else begin
               cmd.avg_start = 1'b1;
               state_in      = ST_AVGWAIT;
            end
         end
         ST_AVGWAIT: begin
            if (stat.div_done) begin
               state_in = (stat.op == CMD_CURRENT) ? ST_FIN : ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.close_wr = 1'b1;
            state_in     = (stat.op == CMD_PUSH) ? ST_REOPEN : ST_FIN;
         end
         ST_REOPEN: begin
            cmd.open_bucket = 1'b1;
            state_in        = ST_AGG;
         end
         ST_AGG: begin
            cmd.agg  = 1'b1;
            state_in = ST_FIN;
         end
         ST_RDWAIT: state_in = ST_FIN;
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/sample_history_bucket_aggregator.sv @@
// Temperature sample history: a raw ring of recent samples plus a coarse ring of
// closed time buckets (start, average, min, max, faults), with indexed reads from
// the oldest entry, current-bucket and latest-reading queries. One request is in
// work at a time; the next is taken in the cycle after its result is loaded into the
// output register, and the block waits before that load while a result sits stalled
// there. A push writes the raw sample and, unless the bucket width is 0, quantizes
// its time to the width on the divider; when the sample falls in a later bucket it
// closes the open one (forming its average first if it holds valid samples) and
// opens the new one. Flush and current-bucket queries form an average only when the
// open bucket holds valid samples. The shared divider retires one quotient bit a
// cycle over a 48-bit dividend, used both to quantize the sample time and to form
// averages.
module sample_history_bucket_aggregator import sha_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_cmd,
   input  logic [31:0]          req_run_id,
   input  logic [31:0]          req_time_ms,
   input  logic signed [15:0]   req_temp,
   input  logic                 req_temp_valid,
   input  logic [7:0]           req_fault_bits,
   input  logic [31:0]          req_seq,
   input  logic [7:0]           req_read_index,
   input  logic signed [15:0]   req_min_temp,
   input  logic signed [15:0]   req_max_temp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ok,
   output logic [31:0]          rsp_out_run,
   output logic [31:0]          rsp_out_ms,
   output logic signed [15:0]   rsp_out_temp,
   output logic                 rsp_out_temp_valid,
   output logic signed [15:0]   rsp_out_min,
   output logic signed [15:0]   rsp_out_max,
   output logic [7:0]           rsp_out_fault,
   output logic [31:0]          rsp_out_seq,
   output logic [RAW_CW-1:0]    rsp_raw_count,
   output logic [COARSE_CW-1:0] rsp_coarse_count,
   output logic [31:0]          rsp_current_run
);

   sha_cmd_type  cmd;
   sha_stat_type stat;

   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sha_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_cmd),
      .req_run_id         (req_run_id),
      .req_time_ms        (req_time_ms),
      .req_temp           (req_temp),
      .req_temp_valid     (req_temp_valid),
      .req_fault_bits     (req_fault_bits),
      .req_seq            (req_seq),
      .req_read_index     (req_read_index),
      .req_min_temp       (req_min_temp),
      .req_max_temp       (req_max_temp),
      .rsp_ok             (rsp_ok),
      .rsp_out_run        (rsp_out_run),
      .rsp_out_ms         (rsp_out_ms),
      .rsp_out_temp       (rsp_out_temp),
      .rsp_out_temp_valid (rsp_out_temp_valid),
      .rsp_out_min        (rsp_out_min),
      .rsp_out_max        (rsp_out_max),
      .rsp_out_fault      (rsp_out_fault),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_raw_count      (rsp_raw_count),
      .rsp_coarse_count   (rsp_coarse_count),
      .rsp_current_run    (rsp_current_run)
   );

endmodule
